// File: design/lds_pkg.sv
package lds_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int COEF_FRAC_DEF = 27;
  localparam int K_FRAC = 30;
  localparam int ERR_FRAC = 16;
  localparam int ORDER_W = 5;
  localparam logic [ORDER_W-1:0] ORDER_RST = 5'd10;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_R0_ZERO    = 2'd1,
    ST_ERR_NONPOS = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_DIV_GO, S_DIV_WAIT,
    S_CPY_RD, S_CPY_WR, S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_AM, S_SQ_CHK,
    S_EH_MUL, S_EL_MUL, S_E_SUM, S_E_CHK, S_OUT_RD, S_OUT_EMIT, S_FAIL
  } state_t;

endpackage

// File: design/lds_ram.sv
module lds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lds_div.sv
module lds_div #(
  parameter int SHIFT = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num_mag,
  input  logic        num_neg,
  input  logic [47:0] den,
  output logic        done,
  output logic [31:0] k
);
  import lds_pkg::*;

  localparam int NBITS = 64 + SHIFT;
  localparam int CW = $clog2(NBITS + 1);
  localparam logic [32:0] CAP = 33'h1_0000_0000;

  logic [NBITS-1:0] num_r;
  logic [47:0]      den_r;
  logic [47:0]      rem_r;
  logic [32:0]      q_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [48:0]      rem_sh;
  logic             qb;
  logic [33:0]      q_sh;
  logic [32:0]      q_nxt;

  always_comb begin
    rem_sh = {rem_r, num_r[NBITS-1]};
    qb     = (rem_sh >= {1'b0, den_r});
    q_sh   = {q_r, qb};
    q_nxt  = (q_sh > {1'b0, CAP}) ? CAP : q_sh[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NBITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {num_mag, {SHIFT{1'b0}}};
      den_r <= den;
      neg_r <= num_neg;
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NBITS-2:0], 1'b0};
      rem_r <= qb ? 48'(rem_sh - {1'b0, den_r}) : rem_sh[47:0];
      q_r   <= q_nxt;
    end
  end

  always_comb begin
    if (neg_r) begin
      k = (q_r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_r[31:0];
    end else if (q_r > 33'h0_8000_0000) begin
      k = 32'h8000_0000;
    end else begin
      k = 32'(33'd0 - q_r);
    end
  end

  assign done = done_r;

endmodule

// File: design/levinson_durbin_ar_solver.sv
// A solve starts on the beat carrying lag rp and is followed by p result beats, or by a
//   single failure beat.
// Throughput: one lag per cycle while loading; busy stays high through solve and output.
// The bit-serial divider (one quotient bit a cycle) and the shared multiplier set the solve time.
// Results leave on out_strobe for one cycle each; the receiver cannot stall.
// Reset (rst_n low at a clock edge): order 10, lag loading restarts, error cleared.
module levinson_durbin_ar_solver #(
  parameter int MAX_ORDER      = lds_pkg::MAX_ORDER_DEF,
  parameter int COEF_FRAC_BITS = lds_pkg::COEF_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               in_autocorr_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lds_pkg::ORDER_W-1:0]      cfg_order,
  output logic                             out_strobe,
  output logic [$clog2(MAX_ORDER+1)-1:0]   out_coef_index,
  output logic signed [31:0]               out_ar_coef,
  output logic signed [31:0]               out_reflection_coef,
  output logic [30:0]                      out_prediction_error,
  output logic [1:0]                       out_status,
  output logic                             out_last
);
  import lds_pkg::*;

  localparam int IDX_W = $clog2(MAX_ORDER + 1);
  localparam int REF_W = $clog2(MAX_ORDER);
  localparam int DIV_SHIFT = K_FRAC + ERR_FRAC - COEF_FRAC_BITS;
  localparam int AM_SHIFT = K_FRAC - COEF_FRAC_BITS;
  localparam logic [5:0] MAXO = 6'(MAX_ORDER);
  localparam logic [31:0] ONE_COEF = 32'(64'd1 << COEF_FRAC_BITS);

  state_t state_r, state_nxt;

  logic [ORDER_W-1:0] order_r;
  logic [IDX_W-1:0]   p_eff, load_cnt_r, load_eff, m_r, i_r;
  logic signed [31:0] r0_r, k_r;
  logic signed [63:0] acc_r, prod_r;
  logic [47:0]        e_r;
  logic [30:0]        f_r;
  logic [54:0]        hi_r;
  logic               sat_r;
  status_t            fail_code_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_y;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_add;
  logic signed [34:0] upd_sum;
  logic signed [31:0] upd_val;
  logic               upd_sat;
  logic [79:0]        e_sum;
  logic [33:0]        sq;
  logic               in_acc;

  logic               lag_we, lag_re, coef_we, coef_re, copy_we, copy_re, ref_we, ref_re;
  logic [IDX_W-1:0]   lag_waddr, lag_raddr, coef_waddr, copy_raddr;
  logic [REF_W-1:0]   ref_waddr, ref_raddr;
  logic [31:0]        lag_rd, coef_rd, copy_rd, ref_rd, coef_wdata;
  logic               div_start, div_done;
  logic [31:0]        div_k;
  logic [63:0]        acc_mag;

  always_comb begin
    if (order_r == '0) begin
      p_eff = IDX_W'(1);
    end else if ({1'b0, order_r} > MAXO) begin
      p_eff = IDX_W'(MAX_ORDER);
    end else begin
      p_eff = IDX_W'(order_r);
    end
    load_eff = (load_cnt_r > p_eff) ? '0 : load_cnt_r;
  end

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD);
  assign in_acc    = start && !busy;

  // shared multiplier
  always_comb begin
    mul_a = {k_r[31], k_r};
    mul_b = {copy_rd[31], copy_rd};
    case (state_r)
      S_DOT_MUL: begin
        mul_a = {coef_rd[31], coef_rd};
        mul_b = {lag_rd[31], lag_rd};
      end
      S_AM:     mul_b = {k_r[31], k_r};
      S_EH_MUL: begin
        mul_a = {9'd0, e_r[47:24]};
        mul_b = {2'd0, f_r};
      end
      S_EL_MUL: begin
        mul_a = {9'd0, e_r[23:0]};
        mul_b = {2'd0, f_r};
      end
      default: ;
    endcase
    mul_y = mul_a * mul_b;
  end

  always_comb begin
    acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};
    if (acc_sum[64] != acc_sum[63]) begin
      acc_add = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_add = acc_sum[63:0];
    end
    upd_sum = 35'(signed'(coef_rd)) + 35'(prod_r >>> K_FRAC);
    upd_sat = (upd_sum > 35'sh0_7FFF_FFFF) || (upd_sum < -35'sh0_8000_0000);
    if (upd_sum > 35'sh0_7FFF_FFFF) begin
      upd_val = 32'sh7FFF_FFFF;
    end else if (upd_sum < -35'sh0_8000_0000) begin
      upd_val = 32'sh8000_0000;
    end else begin
      upd_val = upd_sum[31:0];
    end
    sq      = prod_r[63:30];
    e_sum   = {1'b0, hi_r, 24'd0} + {16'd0, prod_r};
    acc_mag = acc_r[63] ? 64'(64'd0 - acc_r) : acc_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:     if (in_acc && load_eff == p_eff) state_nxt = S_INIT;
      S_INIT:     state_nxt = (r0_r <= 0) ? S_FAIL : S_DOT_RD;
      S_DOT_RD:   state_nxt = S_DOT_MUL;
      S_DOT_MUL:  state_nxt = S_DOT_ACC;
      S_DOT_ACC:  state_nxt = (i_r == m_r - 1'b1) ? S_DIV_GO : S_DOT_RD;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_nxt = S_CPY_RD;
      S_CPY_RD:   state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        if (i_r != m_r - 1'b1) begin
          state_nxt = S_CPY_RD;
        end else begin
          state_nxt = (m_r == IDX_W'(1)) ? S_AM : S_UPD_RD;
        end
      end
      S_UPD_RD:   state_nxt = S_UPD_MUL;
      S_UPD_MUL:  state_nxt = S_UPD_WR;
      S_UPD_WR:   state_nxt = (i_r == m_r - 1'b1) ? S_AM : S_UPD_RD;
      S_AM:       state_nxt = S_SQ_CHK;
      S_SQ_CHK:   state_nxt = (sq[33:30] != '0) ? S_FAIL : S_EH_MUL;
      S_EH_MUL:   state_nxt = S_EL_MUL;
      S_EL_MUL:   state_nxt = S_E_SUM;
      S_E_SUM:    state_nxt = S_E_CHK;
      S_E_CHK: begin
        if (e_r == '0) begin
          state_nxt = S_FAIL;
        end else begin
          state_nxt = (m_r == p_eff) ? S_OUT_RD : S_DOT_RD;
        end
      end
      S_OUT_RD:   state_nxt = S_OUT_EMIT;
      S_OUT_EMIT: state_nxt = (i_r == p_eff) ? S_LOAD : S_OUT_RD;
      S_FAIL:     state_nxt = S_LOAD;
      default:    state_nxt = S_LOAD;
    endcase
  end

  // memory and unit controls, results
  always_comb begin
    lag_we     = in_acc;
    lag_waddr  = load_eff;
    lag_re     = (state_r == S_DOT_RD);
    lag_raddr  = IDX_W'(m_r - i_r);
    coef_re    = (state_r == S_DOT_RD) || (state_r == S_CPY_RD) ||
                 (state_r == S_UPD_RD) || (state_r == S_OUT_RD);
    coef_we    = (state_r == S_INIT) || (state_r == S_UPD_WR) || (state_r == S_AM);
    coef_waddr = i_r;
    coef_wdata = upd_val;
    case (state_r)
      S_INIT: begin
        coef_waddr = '0;
        coef_wdata = ONE_COEF;
      end
      S_AM: begin
        coef_waddr = m_r;
        coef_wdata = 32'(k_r >>> AM_SHIFT);
      end
      default: ;
    endcase
    copy_we    = (state_r == S_CPY_WR);
    copy_re    = (state_r == S_UPD_RD);
    copy_raddr = IDX_W'(m_r - i_r);
    ref_we     = (state_r == S_DIV_WAIT) && div_done;
    ref_waddr  = REF_W'(m_r - 1'b1);
    ref_re     = (state_r == S_OUT_RD);
    ref_raddr  = REF_W'(i_r - 1'b1);
    div_start  = (state_r == S_DIV_GO);

    out_strobe           = 1'b0;
    out_coef_index       = '0;
    out_ar_coef          = '0;
    out_reflection_coef  = '0;
    out_prediction_error = '0;
    out_status           = ST_OK;
    out_last             = 1'b0;
    case (state_r)
      S_OUT_EMIT: begin
        out_strobe           = 1'b1;
        out_coef_index       = i_r;
        out_ar_coef          = coef_rd;
        out_reflection_coef  = ref_rd;
        out_prediction_error = e_r[46:16];
        out_status           = sat_r ? ST_SAT : ST_OK;
        out_last             = (i_r == p_eff);
      end
      S_FAIL: begin
        out_strobe = 1'b1;
        out_status = fail_code_r;
        out_last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      order_r    <= ORDER_RST;
      load_cnt_r <= '0;
      e_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r    <= cfg_order;
        load_cnt_r <= '0;
      end else if (in_acc) begin
        load_cnt_r <= (load_eff == p_eff) ? '0 : IDX_W'(load_eff + 1'b1);
      end
      case (state_r)
        S_INIT:  e_r <= {r0_r[31:0], 16'd0};
        S_E_SUM: e_r <= e_sum[77:30];
        S_FAIL:  e_r <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_y[63:0];
    if (in_acc && load_eff == '0) begin
      r0_r <= in_autocorr_value;
    end
    case (state_r)
      S_INIT: begin
        m_r         <= IDX_W'(1);
        i_r         <= '0;
        acc_r       <= '0;
        sat_r       <= 1'b0;
        fail_code_r <= (r0_r == 0) ? ST_R0_ZERO : ST_ERR_NONPOS;
      end
      S_DOT_ACC: begin
        acc_r <= acc_add;
        if (i_r != m_r - 1'b1) i_r <= i_r + 1'b1;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          k_r <= div_k;
          i_r <= '0;
        end
      end
      S_CPY_WR: i_r <= (i_r == m_r - 1'b1) ? IDX_W'(1) : IDX_W'(i_r + 1'b1);
      S_UPD_WR: begin
        if (upd_sat) sat_r <= 1'b1;
        i_r <= i_r + 1'b1;
      end
      S_SQ_CHK: begin
        f_r         <= 31'(31'h4000_0000 - {1'b0, sq[29:0]});
        fail_code_r <= ST_ERR_NONPOS;
      end
      S_EL_MUL: hi_r <= prod_r[54:0];
      S_E_CHK: begin
        i_r   <= (m_r == p_eff) ? IDX_W'(1) : '0;
        acc_r <= '0;
        if (m_r != p_eff) m_r <= m_r + 1'b1;
      end
      S_OUT_EMIT: if (i_r != p_eff) i_r <= i_r + 1'b1;
      default: ;
    endcase
  end

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_lag (
    .clk(clk), .we(lag_we), .waddr(lag_waddr), .wdata(in_autocorr_value),
    .re(lag_re), .raddr(lag_raddr), .rdata(lag_rd)
  );

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .re(coef_re), .raddr(i_r), .rdata(coef_rd)
  );

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_copy (
    .clk(clk), .we(copy_we), .waddr(i_r), .wdata(coef_rd),
    .re(copy_re), .raddr(copy_raddr), .rdata(copy_rd)
  );

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_refl (
    .clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(div_k),
    .re(ref_re), .raddr(ref_raddr), .rdata(ref_rd)
  );

  lds_div #(.SHIFT(DIV_SHIFT)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num_mag(acc_mag),
    .num_neg(acc_r[63]), .den(e_r), .done(div_done), .k(div_k)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result beat while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !busy) else $error("block still busy after last beat");

  a_fail_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_R0_ZERO || out_status == ST_ERR_NONPOS) |->
    out_last && out_coef_index == '0) else $error("failure beat malformed");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT) else $error("divider finished unexpectedly");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> load_cnt_r == '0) else $error("order write did not restart load");

endmodule

// File: bench/lds_checker.sv
`timescale 1ns / 100ps
module lds_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_autocorr_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [4:0]         cfg_order,
  input  logic               out_strobe,
  input  logic [4:0]         out_coef_index,
  input  logic signed [31:0] out_ar_coef,
  input  logic signed [31:0] out_reflection_coef,
  input  logic [30:0]        out_prediction_error,
  input  logic [1:0]         out_status,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 solves_seen
);
  import lds_pkg::*;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] ar;
    logic [31:0] refl;
    logic [30:0] perr;
    logic [1:0]  st;
    logic        last;
  } coef_beat_t;

  coef_beat_t coef_q[$];
  logic signed [31:0] lags[17];
  logic signed [31:0] poly[17];
  logic signed [31:0] poly_old[17];
  logic signed [31:0] refl[16];
  logic [4:0] order_reg;
  int unsigned load_cnt;

  assign pending = coef_q.size();

  function automatic int unsigned eff_p();
    if (order_reg < 1) return 1;
    if (order_reg > MAX_ORDER_DEF) return MAX_ORDER_DEF;
    return order_reg;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7FFFFFFFFFFFFFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
    return s;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint divide_k(longint acc, logic [63:0] e);
    int s;
    logic [63:0] n, rem, q, b;
    s = K_FRAC + ERR_FRAC - COEF_FRAC_DEF;
    n = acc < 0 ? -acc : acc;
    rem = 0;
    q = 0;
    for (int j = 63 + s; j >= 0; j--) begin
      b = (j >= s) ? ((n >> (j - s)) & 1) : 0;
      rem = (rem << 1) | b;
      if (rem >= e) begin
        rem = rem - e;
        q = (q << 1) | 1;
      end else begin
        q = q << 1;
      end
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    end
    if (acc < 0) return q > 64'h7FFFFFFF ? 64'sh7FFFFFFF : longint'(q);
    if (q > 64'h80000000) q = 64'h80000000;
    return -longint'(q);
  endfunction

  function automatic logic [63:0] shrink_err(logic [63:0] e, logic [63:0] f);
    logic [63:0] hi, lo;
    hi = (e >> 24) * f;
    lo = (e & 64'hFFFFFF) * f;
    return (hi >> 6) + ((((hi & 63) << 24) + lo) >> 30);
  endfunction

  task automatic push_fail(status_t st);
    coef_beat_t b;
    b = '0;
    b.st = st;
    b.last = 1'b1;
    coef_q.push_back(b);
  endtask

  task automatic predict_solve(int unsigned p);
    logic [63:0] e, mag, sq;
    longint acc, k, t;
    logic sat;
    coef_beat_t b;
    sat = 0;
    if (lags[0] == 0) begin
      push_fail(ST_R0_ZERO);
      return;
    end
    if (lags[0] < 0) begin
      push_fail(ST_ERR_NONPOS);
      return;
    end
    e = 64'(lags[0]) << ERR_FRAC;
    poly[0] = 32'sd1 <<< COEF_FRAC_DEF;
    for (int m = 1; m <= p; m++) begin
      acc = 0;
      for (int i = 0; i < m; i++)
        acc = sat_add(acc, longint'(poly[i]) * longint'(lags[m-i]));
      k = divide_k(acc, e);
      refl[m-1] = k[31:0];
      for (int i = 0; i < m; i++) poly_old[i] = poly[i];
      for (int i = 1; i < m; i++) begin
        t = longint'(poly_old[i]) + floor_shr(k * longint'(poly_old[m-i]), K_FRAC);
        if (t > 64'sh7FFFFFFF) begin
          t = 64'sh7FFFFFFF;
          sat = 1;
        end
        if (t < -64'sh80000000) begin
          t = -64'sh80000000;
          sat = 1;
        end
        poly[i] = t[31:0];
      end
      t = floor_shr(k, K_FRAC - COEF_FRAC_DEF);
      poly[m] = t[31:0];
      mag = k < 0 ? -k : k;
      sq = (mag * mag) >> K_FRAC;
      if (sq >= (64'd1 << K_FRAC)) begin
        push_fail(ST_ERR_NONPOS);
        return;
      end
      e = shrink_err(e, (64'd1 << K_FRAC) - sq);
      if (e == 0) begin
        push_fail(ST_ERR_NONPOS);
        return;
      end
    end
    for (int i = 1; i <= p; i++) begin
      b.idx = 5'(i);
      b.ar = poly[i];
      b.refl = refl[i-1];
      b.perr = e[46:16];
      b.st = sat ? ST_SAT : ST_OK;
      b.last = (i == p);
      coef_q.push_back(b);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    coef_beat_t w;
    if (!rst_n) begin
      order_reg <= ORDER_RST;
      load_cnt = 0;
      fail_count = 0;
      solves_seen = 0;
      coef_q.delete();
    end else begin
      if (out_strobe) begin
        if (coef_q.size() == 0) begin
          report("unexpected beat", 32'(out_coef_index), 32'd0);
        end else begin
          w = coef_q.pop_front();
          if (out_coef_index !== w.idx)
            report("coef_index", 32'(out_coef_index), 32'(w.idx));
          if (out_ar_coef !== w.ar) report("ar_coef", out_ar_coef, w.ar);
          if (out_reflection_coef !== w.refl)
            report("reflection", out_reflection_coef, w.refl);
          if (out_prediction_error !== w.perr)
            report("pred_error", 32'(out_prediction_error), 32'(w.perr));
          if (out_status !== w.st) report("status", 32'(out_status), 32'(w.st));
          if (out_last !== w.last) report("last", 32'(out_last), 32'(w.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        order_reg <= cfg_order;
        load_cnt = 0;
      end else if (start && !busy) begin
        if (load_cnt > eff_p()) load_cnt = 0;
        lags[load_cnt] = in_autocorr_value;
        load_cnt++;
        if (load_cnt > eff_p()) begin
          load_cnt = 0;
          solves_seen++;
          predict_solve(eff_p());
        end
      end
    end
  end
endmodule

// File: bench/tb_levinson_durbin_ar_solver.sv
`timescale 1ns / 100ps
module tb_levinson_durbin_ar_solver;
  import lds_pkg::*;

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready;
  logic signed [31:0] in_autocorr_value;
  logic [4:0] cfg_order;
  logic out_strobe, out_last;
  logic [4:0] out_coef_index;
  logic signed [31:0] out_ar_coef, out_reflection_coef;
  logic [30:0] out_prediction_error;
  logic [1:0] out_status;
  int fail_count, pending, solves_seen, lag_beats;

  levinson_durbin_ar_solver uut (.*);

  lds_checker chk (
    .clk, .rst_n, .start, .busy, .in_autocorr_value, .cfg_valid, .cfg_ready,
    .cfg_order, .out_strobe, .out_coef_index, .out_ar_coef, .out_reflection_coef,
    .out_prediction_error, .out_status, .out_last,
    .fail_count, .pending, .solves_seen
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_lag(logic signed [31:0] v);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_autocorr_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    lag_beats++;
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_order(logic [4:0] p);
    drain();
    cfg_valid <= 1;
    cfg_order <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // decaying sequence gives a well-conditioned Toeplitz system
  task automatic send_set(int unsigned p, int r0);
    int v;
    int sgn;
    send_lag(r0);
    v = r0;
    sgn = $urandom_range(0, 1);
    for (int i = 1; i <= p; i++) begin
      v = v / 2 + $signed($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      send_lag(sgn && i[0] ? -v : v);
    end
  endtask

  initial begin
    int unsigned p;
    rst_n = 0;
    start = 0;
    cfg_valid = 0;
    cfg_order = 0;
    in_autocorr_value = 0;
    lag_beats = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset order 10
    send_set(10, 32'h4000_0000);
    write_order(5'd1);
    send_lag(0); send_lag(5);
    send_lag(-32'sh8000_0000); send_lag(5);
    send_lag(32'sh7FFF_FFFF); send_lag(32'sh7FFF_FFFF);
    send_lag(100); send_lag(-32'sh8000_0000);
    send_lag(1); send_lag(0);
    write_order(5'd2);
    send_lag(1000); send_lag(999); send_lag(-1000);
    write_order(5'd16);
    send_set(16, 1 << 20);
    write_order(5'd0);
    send_lag(-1); send_lag(32'sh5555_AAAA);
    write_order(5'd31);
    send_set(16, 32'sh7FFF_FFFF);
    while (lag_beats < 125) begin
      p = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) p = 16;
      write_order(5'(p));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: for (int i = 0; i <= p; i++) send_lag($urandom);
          1: send_lag($urandom);
          default: send_set(p, $urandom_range(1, 32'h7FFF_FFFF));
        endcase
        if ($urandom_range(0, 3) == 0) drain();
      end
    end
    drain();
    $display("Covered %0d lag beats, %0d solves, orders 0..31 incl. r0 zero/negative.",
             lag_beats, solves_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
